/* rtl/kwsu_pkg.sv */
// Shared constants, heap entry type and ordering function of the k-way union merge.
package kwsu_pkg;

   localparam int SOURCES = 16;
   localparam int ID_BITS = 32;
   localparam int IDX_W   = $clog2(SOURCES);
   localparam int CNT_W   = $clog2(SOURCES + 1);

   localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};

   typedef struct packed {
      logic [ID_BITS-1:0] key;
      logic [IDX_W-1:0]   stream;
      logic               fresh;
   } heap_entry_type;

   // A orders at or before B; an entry without an id yet orders before every id.
   function automatic logic at_or_before(input heap_entry_type a, input heap_entry_type b);
      logic res;
      if (a.fresh) begin
         res = 1'b1;
      end else if (b.fresh) begin
         res = 1'b0;
      end else begin
         res = (a.key <= b.key);
      end
      return res;
   endfunction

endpackage

/* rtl/kwsu_heap.sv */
// Heap storage: one write port, two registered read ports, per-entry valid bits.
module kwsu_heap (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  logic                    wr_en,
   input  logic [kwsu_pkg::IDX_W-1:0] wr_addr,
   input  kwsu_pkg::heap_entry_type   wr_data,
   input  logic [kwsu_pkg::IDX_W-1:0] rd_addr_a,
   input  logic [kwsu_pkg::IDX_W-1:0] rd_addr_b,
   output kwsu_pkg::heap_entry_type   rd_data_a,
   output kwsu_pkg::heap_entry_type   rd_data_b
);
   import kwsu_pkg::*;

   heap_entry_type       mem [SOURCES];
   logic [SOURCES-1:0]   valid_ff;
   heap_entry_type       q_a_ff;
   heap_entry_type       q_b_ff;
   logic                 q_a_valid_ff;
   logic                 q_b_valid_ff;
   logic [IDX_W-1:0]     q_a_addr_ff;
   logic [IDX_W-1:0]     q_b_addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_a_ff      <= mem[rd_addr_a];
      q_b_ff      <= mem[rd_addr_b];
      q_a_addr_ff <= rd_addr_a;
      q_b_addr_ff <= rd_addr_b;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff     <= '0;
         q_a_valid_ff <= 1'b0;
         q_b_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         q_a_valid_ff <= valid_ff[rd_addr_a];
         q_b_valid_ff <= valid_ff[rd_addr_b];
      end
   end

   // An entry never written since restart reads as its reset value: stream i, no id yet.
   always_comb begin
      if (q_a_valid_ff) begin
         rd_data_a = q_a_ff;
      end else begin
         rd_data_a.key    = '0;
         rd_data_a.stream = q_a_addr_ff;
         rd_data_a.fresh  = 1'b1;
      end
      if (q_b_valid_ff) begin
         rd_data_b = q_b_ff;
      end else begin
         rd_data_b.key    = '0;
         rd_data_b.stream = q_b_addr_ff;
         rd_data_b.fresh  = 1'b1;
      end
   end

endmodule

/* rtl/kway_sorted_union_merge.sv */
// Top level of the k-way sorted union merge with its sift-down sequencer.
//
// The block merges up to 16 ascending id streams into their duplicate-free union,
// keeping a min-heap of each live stream's current id. Each request word is either
// the named stream's reply (tuser bit 0 low: new id, or end of stream in tuser bit 1)
// or a seek request (tuser bit 0 high). Each request yields exactly one response word
// naming the stream to fetch next and, when it passes the threshold, the next union id.
// A reply sinks its new id from the root: ST_ISSUE, one ST_CMP step per heap level
// descended (at most 4 levels), ST_PLACE on reaching a leaf, then ST_FINISH; with a
// single live stream ST_ISSUE goes straight to ST_FINISH. End of stream first passes
// ST_LOAD to read the last heap entry while streams remain. A seek, the end of the last
// stream, or a request after all streams are done goes straight to ST_FINISH, where the
// response word waits for rsp_tready. Sift-down uses the compare logic and both heap
// read ports once per level. A csr write restarts the merge with the new stream count.
module kway_sorted_union_merge (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,   // source_count
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,     // reply_doc [31:0], seek_target [63:32]
   input  logic [1:0]  req_tuser,     // func [0], reply_exhausted [1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,     // fetch_source [3:0], fetch_target [35:4],
                                      // union_id [67:36], zero fill [71:68]
   output logic [2:0]  rsp_tuser      // fetch_is_seek [0], emit_valid [1], all_done [2]
);
   import kwsu_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_ISSUE  = 3'd2;
   localparam logic [2:0] ST_CMP    = 3'd3;
   localparam logic [2:0] ST_PLACE  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   localparam logic [CNT_W-1:0] SRC_MAX = CNT_W'(SOURCES);

   logic [2:0]           state_ff, state_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   heap_entry_type       cur_ff, cur_in;
   heap_entry_type       root_ff, root_in;
   logic                 check_ff, check_in;
   logic [CNT_W-1:0]     live_ff, live_in;
   logic [ID_BITS-1:0]   last_ff, last_in;
   logic                 emitted_ff, emitted_in;
   logic [ID_BITS-1:0]   bound_ff, bound_in;
   logic                 seek_ff, seek_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [71:0]          rsp_data_ff, rsp_data_in;
   logic [2:0]           rsp_user_ff, rsp_user_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   heap_entry_type       wr_data;
   logic [IDX_W-1:0]     rd_addr_a;
   logic [IDX_W-1:0]     rd_addr_b;
   heap_entry_type       rd_a;
   heap_entry_type       rd_b;

   logic                 req_accept;
   logic [IDX_W:0]       left_idx;
   logic [IDX_W+1:0]     right_idx;
   logic                 take_right;
   heap_entry_type       child;
   logic [IDX_W-1:0]     child_idx;
   logic [IDX_W:0]       next_left;
   logic [IDX_W+1:0]     next_right;
   logic [CNT_W-1:0]     live_dec;
   logic [ID_BITS-1:0]   seek_t;
   logic                 pass;
   logic                 emit;
   logic                 rsp_free;
   logic [CNT_W-1:0]     csr_count;

   kwsu_heap u_heap (
      .clock     (clock),
      .reset     (reset),
      .clear     (csr_wr_en),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_count  = (csr_wr_data > SRC_MAX) ? SRC_MAX : csr_wr_data;

   // Children of the current hole and of the child chosen in this compare step.
   assign left_idx   = {pos_ff, 1'b1};
   assign right_idx  = {1'b0, pos_ff, 1'b0} + (IDX_W+2)'(2);
   assign take_right = ((IDX_W+2)'(live_ff) > right_idx) && at_or_before(rd_b, rd_a);
   assign child      = take_right ? rd_b : rd_a;
   assign child_idx  = take_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
   assign next_left  = {child_idx, 1'b1};
   assign next_right = {1'b0, child_idx, 1'b0} + (IDX_W+2)'(2);
   assign live_dec   = live_ff - CNT_W'(1);

   assign seek_t = (emitted_ff && (req_tdata[63:32] <= last_ff))
                   ? ((last_ff < ID_MAX) ? last_ff + ID_BITS'(1) : ID_MAX)
                   : req_tdata[63:32];

   assign pass = (!emitted_ff || (root_ff.key > last_ff))
                 && !(seek_ff && (root_ff.key < bound_ff));
   assign emit = check_ff && (live_ff != '0) && !root_ff.fresh && pass;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      root_in      = root_ff;
      check_in     = check_ff;
      live_in      = live_ff;
      last_in      = last_ff;
      emitted_in   = emitted_ff;
      bound_in     = bound_ff;
      seek_in      = seek_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cur_ff;
      rd_addr_a    = left_idx[IDX_W-1:0];
      rd_addr_b    = right_idx[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               check_in = 1'b0;
               state_in = ST_FINISH;
               pos_in   = '0;
               if (live_ff != '0) begin
                  if (req_tuser[0]) begin
                     bound_in = seek_t;
                     seek_in  = 1'b1;
                  end else if (req_tuser[1]) begin
                     live_in  = live_dec;
                     check_in = 1'b1;
                     if (live_dec != '0) begin
                        // The last live entry moves to the root and sinks from there.
                        rd_addr_a = live_dec[IDX_W-1:0];
                        state_in  = ST_LOAD;
                     end
                  end else begin
                     cur_in.key    = req_tdata[ID_BITS-1:0];
                     cur_in.stream = root_ff.stream;
                     cur_in.fresh  = 1'b0;
                     check_in      = 1'b1;
                     state_in      = ST_ISSUE;
                  end
               end
            end
         end
         ST_LOAD: begin
            cur_in   = rd_a;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            if ((IDX_W+1)'(live_ff) > left_idx) begin
               state_in = ST_CMP;
            end else begin
               wr_en    = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_CMP: begin
            wr_en = 1'b1;
            if (at_or_before(cur_ff, child)) begin
               state_in = ST_FINISH;
            end else begin
               wr_data   = child;
               pos_in    = child_idx;
               rd_addr_a = next_left[IDX_W-1:0];
               rd_addr_b = next_right[IDX_W-1:0];
               state_in  = ((IDX_W+1)'(live_ff) > next_left) ? ST_CMP : ST_PLACE;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_user_in  = '0;
               if (emit) begin
                  last_in    = root_ff.key;
                  emitted_in = 1'b1;
                  seek_in    = 1'b0;
                  rsp_data_in[67:36] = root_ff.key;
                  rsp_user_in[1]     = 1'b1;
               end
               if (live_ff == '0) begin
                  rsp_user_in[2] = 1'b1;
               end else begin
                  rsp_data_in[3:0] = root_ff.stream;
                  if (seek_ff && !emit) begin
                     rsp_user_in[0]    = 1'b1;
                     rsp_data_in[35:4] = bound_ff;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The root is mirrored in registers so the result needs no extra memory read.
      if (wr_en && (wr_addr == '0)) begin
         root_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         state_ff       <= ST_IDLE;
         root_ff.key    <= '0;
         root_ff.stream <= '0;
         root_ff.fresh  <= 1'b1;
         live_ff        <= reset ? CNT_W'(2) : csr_count;
         last_ff        <= '0;
         emitted_ff     <= 1'b0;
         bound_ff       <= '0;
         seek_ff        <= 1'b0;
         check_ff       <= 1'b0;
      end else begin
         state_ff   <= state_in;
         root_ff    <= root_in;
         live_ff    <= live_in;
         last_ff    <= last_in;
         emitted_ff <= emitted_in;
         bound_ff   <= bound_in;
         seek_ff    <= seek_in;
         check_ff   <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

/* sim/tb_kway_sorted_union_merge.sv */
// Self-checking testbench of the k-way sorted union merge, with its own heap predictor.
`timescale 1ns / 1ps

module tb_kway_sorted_union_merge;
   import kwsu_pkg::*;

   localparam int CHK          = 0;     // state copy that follows accepted words
   localparam int PLAN         = 1;     // state copy that plans well-formed stream replies
   localparam int LIVE_ITEMS   = 1300;
   localparam int CALM_AFTER   = 1100;
   localparam int PHASE_ITEMS  = 250;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_LIMIT  = 40;

   typedef enum logic { FUNC_REPLY = 1'b0, FUNC_SEEK = 1'b1 } func_type;

   typedef struct packed {
      func_type           func;
      logic [ID_BITS-1:0] doc;
      logic               exhausted;
      logic [ID_BITS-1:0] target;
   } merge_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   src;
      logic               seek;
      logic [ID_BITS-1:0] target;
      logic               emit;
      logic [ID_BITS-1:0] id;
      logic               done;
   } merge_rsp_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [4:0]  csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // reply_doc [31:0], seek_target [63:32]
   logic [1:0]  req_tuser = '0;    // func [0], reply_exhausted [1]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // fetch_source [3:0], fetch_target [35:4], union_id [67:36]
   logic [2:0]  rsp_tuser;         // fetch_is_seek [0], emit_valid [1], all_done [2]

   kway_sorted_union_merge dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   // Two copies of the merge state: one checks the block, one steers the stimulus.
   heap_entry_type     heap [2][SOURCES];
   logic [CNT_W-1:0]   live [2];
   logic [ID_BITS-1:0] last_id [2];
   logic [ID_BITS-1:0] bound [2];
   logic               emitted [2];
   logic               seeking [2];

   merge_req_type req_q [$];
   merge_rsp_type want_q [$];
   merge_rsp_type plan_last;

   int  queued_items = 0;
   int  queued_live = 0;
   int  accepted_items = 0;
   int  words_seen = 0;
   int  mismatches = 0;
   int  cycles = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   bit  calm = 1'b0;
   bit  hold_req = 1'b0;
   bit  hold_taken = 1'b0;

   function automatic void merge_restart(input int w, input logic [4:0] count);
      for (int s = 0; s < SOURCES; s++) begin
         heap[w][s].key    = '0;
         heap[w][s].stream = IDX_W'(s);
         heap[w][s].fresh  = 1'b1;
      end
      live[w]    = (count > SOURCES) ? CNT_W'(SOURCES) : CNT_W'(count);
      last_id[w] = '0;
      emitted[w] = 1'b0;
      bound[w]   = '0;
      seeking[w] = 1'b0;
   endfunction

   // An entry without an id yet sorts ahead of every id.
   function automatic logic precedes(input int w, input int a, input int b);
      logic res;
      if (heap[w][a].fresh) begin
         res = 1'b1;
      end else if (heap[w][b].fresh) begin
         res = 1'b0;
      end else begin
         res = (heap[w][a].key <= heap[w][b].key);
      end
      return res;
   endfunction

   function automatic void swap_entries(input int w, input int a, input int b);
      heap_entry_type t;
      t = heap[w][a];
      heap[w][a] = heap[w][b];
      heap[w][b] = t;
   endfunction

   function automatic void sift_down(input int w);
      int i, l, r, c;
      i = 0;
      while (2 * i + 1 < int'(live[w])) begin
         l = 2 * i + 1;
         r = l + 1;
         c = l;
         if (r < int'(live[w]) && precedes(w, r, l)) c = r;
         if (precedes(w, i, c)) break;
         swap_entries(w, i, c);
         i = c;
      end
   endfunction

   function automatic merge_rsp_type merge_step(input int w, input merge_req_type rq);
      merge_rsp_type r;
      logic fire;
      logic [ID_BITS-1:0] k;
      logic [ID_BITS-1:0] t;
      r = '0;
      fire = 1'b0;
      k = '0;
      if (live[w] != 0) begin
         if (rq.func == FUNC_SEEK) begin
            t = rq.target;
            if (emitted[w] && t <= last_id[w]) begin
               t = (last_id[w] != ID_MAX) ? last_id[w] + 1'b1 : ID_MAX;
            end
            bound[w] = t;
            seeking[w] = 1'b1;
         end else begin
            if (rq.exhausted) begin
               live[w] = live[w] - 1'b1;
               if (live[w] != 0) begin
                  swap_entries(w, 0, int'(live[w]));
                  sift_down(w);
               end
            end else begin
               heap[w][0].key = rq.doc;
               heap[w][0].fresh = 1'b0;
               sift_down(w);
            end
            if (live[w] != 0 && !heap[w][0].fresh) begin
               k = heap[w][0].key;
               fire = !emitted[w] || k > last_id[w];
               if (seeking[w] && k < bound[w]) fire = 1'b0;
               if (fire) begin
                  last_id[w] = k;
                  emitted[w] = 1'b1;
                  seeking[w] = 1'b0;
               end
            end
         end
      end
      r.emit = fire;
      r.id = fire ? k : '0;
      if (live[w] == 0) begin
         r.done = 1'b1;
      end else begin
         r.src = heap[w][0].stream;
         r.seek = seeking[w];
         r.target = seeking[w] ? bound[w] : '0;
      end
      return r;
   endfunction

   function automatic void queue_item(input merge_req_type rq);
      if (live[PLAN] != 0) queued_live++;
      if (queued_live > CALM_AFTER) calm = 1'b1;
      plan_last = merge_step(PLAN, rq);
      req_q.insert(req_q.size(), rq);
      queued_items++;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_LIMIT) begin
         $display("MISMATCH word %0d: %s got %0h want %0h", words_seen, what, got, want);
      end
      mismatches++;
   endtask

   task automatic write_count(input logic [4:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      merge_restart(CHK, value);
      merge_restart(PLAN, value);
      plan_last = '0;
   endtask

   task automatic drain();
      while (accepted_items != queued_items || want_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Streams ascend from a common base so that ids collide across streams. The planner
   // copy tells which stream is named next and whether it was asked to seek.
   task automatic random_phase(input logic [4:0] count);
      logic [ID_BITS-1:0] cur [SOURCES];
      int                 left [SOURCES];
      logic               started [SOURCES];
      logic [ID_BITS-1:0] base;
      logic [ID_BITS:0]   nxt;
      merge_req_type      rq;
      int                 spread, n, pick, s;
      write_count(count);
      pick = $urandom_range(0, 9);
      if (pick < 6) base = $urandom_range(0, 40);
      else if (pick < 8) base = $urandom();
      else base = ID_MAX - $urandom_range(0, 60);
      spread = $urandom_range(0, 30);
      for (int i = 0; i < SOURCES; i++) begin
         nxt = {1'b0, base} + $urandom_range(0, spread);
         cur[i] = nxt[ID_BITS] ? ID_MAX : nxt[ID_BITS-1:0];
         left[i] = $urandom_range(0, 10);
         started[i] = 1'b0;
      end
      n = 0;
      while (n < PHASE_ITEMS && live[PLAN] != 0) begin
         pick = $urandom_range(0, 99);
         s = int'(plan_last.src);
         rq.func = FUNC_REPLY;
         rq.doc = $urandom();
         rq.exhausted = ($urandom_range(0, 3) == 0);
         rq.target = $urandom();
         if (pick < 5) begin
            rq.func = func_type'($urandom_range(0, 1));
         end else if (pick < 13) begin
            rq.func = FUNC_SEEK;
            if (pick >= 7) rq.target = last_id[PLAN] - 3 + $urandom_range(0, 25);
         end else if (left[s] == 0) begin
            rq.exhausted = 1'b1;
         end else begin
            rq.exhausted = 1'b0;
            nxt = {1'b0, cur[s]};
            if (started[s]) begin
               nxt = nxt + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 500)
                                                        : $urandom_range(1, 3));
            end
            if (plan_last.seek && nxt < {1'b0, plan_last.target}) begin
               nxt = {1'b0, plan_last.target};
            end
            if (nxt[ID_BITS]) begin
               rq.exhausted = 1'b1;
            end else begin
               rq.doc = nxt[ID_BITS-1:0];
               cur[s] = rq.doc;
               started[s] = 1'b1;
               left[s]--;
            end
         end
         queue_item(rq);
         n++;
      end
      // Up to two more random words; once the merge is over, the block must answer them as done.
      repeat ($urandom_range(0, 2)) begin
         rq.func = func_type'($urandom_range(0, 1));
         rq.doc = $urandom();
         rq.exhausted = $urandom_range(0, 1);
         rq.target = $urandom();
         queue_item(rq);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Request driver: predicts each word at the edge where it is taken.
   always @(posedge clock) begin
      merge_req_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            rq.func = func_type'(req_tuser[0]);
            rq.exhausted = req_tuser[1];
            rq.doc = req_tdata[31:0];
            rq.target = req_tdata[63:32];
            want_q.insert(want_q.size(), merge_step(CHK, rq));
            accepted_items++;
            if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 5);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               req_tvalid <= 1'b0;
               gap_left--;
            end else if (req_q.size() != 0) begin
               rq = req_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {rq.target, rq.doc};
               req_tuser  <= {rq.exhausted, rq.func};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response ready: random short stalls, plus one long hold-off so the block backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      merge_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (want_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[31:0], '0);
         end else begin
            want = want_q.pop_front();
            if (rsp_tdata[3:0] != want.src)
               report_mismatch("fetch_source", rsp_tdata[3:0], want.src);
            if (rsp_tuser[0] != want.seek)
               report_mismatch("fetch_is_seek", rsp_tuser[0], want.seek);
            if (rsp_tdata[35:4] != want.target)
               report_mismatch("fetch_target", rsp_tdata[35:4], want.target);
            if (rsp_tuser[1] != want.emit)
               report_mismatch("emit_valid", rsp_tuser[1], want.emit);
            if (rsp_tdata[67:36] != want.id)
               report_mismatch("union_id", rsp_tdata[67:36], want.id);
            if (rsp_tuser[2] != want.done)
               report_mismatch("all_done", rsp_tuser[2], want.done);
         end
      end
   end

   initial begin
      logic [4:0] count;
      merge_restart(CHK, 5'd2);
      merge_restart(PLAN, 5'd2);
      plan_last = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Two streams from reset: id zero, duplicates, seek clamping and replacement,
      // the largest id with a saturated bound, end of every stream and words after it.
      queue_item('{FUNC_REPLY, 32'd0, 1'b0, 32'd0});
      queue_item('{FUNC_REPLY, 32'd0, 1'b0, ID_MAX});
      queue_item('{FUNC_REPLY, 32'd5, 1'b0, 32'd0});
      queue_item('{FUNC_SEEK, ID_MAX, 1'b0, 32'd3});
      queue_item('{FUNC_SEEK, 32'd0, 1'b1, 32'd0});
      queue_item('{FUNC_REPLY, 32'd7, 1'b0, 32'd0});
      queue_item('{FUNC_REPLY, ID_MAX, 1'b0, 32'd0});
      queue_item('{FUNC_SEEK, 32'd0, 1'b0, ID_MAX});
      queue_item('{FUNC_REPLY, ID_MAX - 1, 1'b0, 32'd0});
      queue_item('{FUNC_REPLY, ID_MAX, 1'b0, 32'd0});
      queue_item('{FUNC_SEEK, 32'd0, 1'b0, 32'd0});
      queue_item('{FUNC_REPLY, ID_MAX, 1'b0, ID_MAX});
      queue_item('{FUNC_REPLY, 32'd0, 1'b1, 32'd0});
      queue_item('{FUNC_REPLY, ID_MAX, 1'b1, ID_MAX});
      queue_item('{FUNC_REPLY, 32'd5, 1'b0, 32'd0});
      queue_item('{FUNC_SEEK, 32'd0, 1'b0, 32'd9});
      drain();

      // No streams at all: the merge is done from the start.
      write_count(5'd0);
      queue_item('{FUNC_REPLY, 32'd1, 1'b0, 32'd0});
      queue_item('{FUNC_SEEK, 32'd0, 1'b0, 32'd4});
      drain();

      random_phase(5'd16);
      hold_req = 1'b1;
      drain();
      random_phase(5'd1);
      drain();
      random_phase(5'd31);
      drain();
      random_phase(5'd17);
      drain();
      random_phase(5'd0);
      drain();
      while (queued_live < LIVE_ITEMS) begin
         case ($urandom_range(0, 3))
            0: count = 5'd16;
            1: count = $urandom_range(0, 31);
            default: count = $urandom_range(1, 16);
         endcase
         random_phase(count);
         drain();
      end

      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
